### src/jgd_pkg.sv
// Shared types, register codes and reset values for the jerk and gesture detector.
`default_nettype none
package jgd_pkg;

    // Field widths
    localparam int unsigned ACCEL_W    = 16;
    localparam int unsigned COUNT_W    = 8;
    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned GTHRESH_W  = 15;
    localparam int unsigned NOW_W      = 32;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned NUM_AXES   = 3;
    localparam int unsigned AXIS_W     = 2;

    localparam int unsigned DEF_TIME_WIDTH = 32;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // Register reset values
    localparam logic signed [ACCEL_W-1:0] RST_ACCEL_THRESHOLD   = 16'sd3200;
    localparam logic [COUNT_W-1:0]        RST_COUNT_LIMIT       = 8'd15;
    localparam logic [WINDOW_W-1:0]       RST_WINDOW_LENGTH     = 16'd3000;
    localparam logic [COUNT_W-1:0]        RST_WARNING_LIMIT     = 8'd3;
    localparam logic [GTHRESH_W-1:0]      RST_GESTURE_THRESHOLD = 15'd5120;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACCEL_THRESHOLD   = 3'd0,
        REG_COUNT_LIMIT       = 3'd1,
        REG_WINDOW_LENGTH     = 3'd2,
        REG_WARNING_LIMIT     = 3'd3,
        REG_GESTURE_THRESHOLD = 3'd4
    } t_cfg_reg;

    // Axis codes
    typedef enum logic [AXIS_W-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    // Control shared by all lanes for the item in flight
    typedef struct packed {
        logic advance;  // item accepted this cycle
        logic expire;   // window restarts with this item
        logic jerk;     // merge stage flagged a jerk
    } t_lane_ctrl;

    // One result item
    typedef struct packed {
        logic               motion;
        logic               jerk;
        logic [AXIS_W-1:0]  jerk_axis;
        logic               alert;
        logic [COUNT_W-1:0] warning_count;
        logic               gesture;
    } t_result;

endpackage : jgd_pkg
`default_nettype wire

### src/jerk_and_gesture_detector_unit.sv
// Top level of the jerk and gesture detector: config registers, window timer, lanes, output.
`default_nettype none
// Takes one motion sample per clock while ready and returns one result item for each.
// The three acceleration axes run in parallel lanes, and a merge stage does
// the axis priority, warning count and gyro gesture check in the same cycle,
// so a sample's result lands in the output register in the cycle after it is
// accepted. The input is ready whenever the output register is empty or its
// item is being taken in that cycle; with the output side always ready the
// block sustains one item per clock. Configuration writes take effect at
// the next clock edge.
module jerk_and_gesture_detector_unit #(
    parameter int unsigned TIME_WIDTH = jgd_pkg::DEF_TIME_WIDTH
) (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    // Configuration write port
    input  wire logic                                   i_cfg_we,
    input  wire logic [jgd_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  wire logic [jgd_pkg::CFG_DATA_W-1:0]         i_cfg_data,
    // Sample input
    input  wire logic                                   i_valid,
    output logic                                        o_ready,
    input  wire logic [jgd_pkg::NOW_W-1:0]              i_now_ms,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]     i_accel_x,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]     i_accel_y,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]     i_accel_z,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]     i_gyro_x,
    // Result output
    output logic                                        o_valid,
    input  wire logic                                   i_ready,
    output logic                                        o_motion,
    output logic                                        o_jerk,
    output logic [jgd_pkg::AXIS_W-1:0]                  o_jerk_axis,
    output logic                                        o_alert,
    output logic [jgd_pkg::COUNT_W-1:0]                 o_warning_count,
    output logic                                        o_gesture
);
    import jgd_pkg::*;

    logic signed [ACCEL_W-1:0] r_accel_threshold;
    logic [COUNT_W-1:0]        r_count_limit;
    logic [WINDOW_W-1:0]       r_window_length;
    logic [COUNT_W-1:0]        r_warning_limit;
    logic [GTHRESH_W-1:0]      r_gesture_threshold;

    logic [TIME_WIDTH-1:0]     r_window_start;
    logic [TIME_WIDTH-1:0]     now_t;
    logic [TIME_WIDTH-1:0]     elapsed;

    logic                      advance;
    t_lane_ctrl                lane_ctrl;
    logic [NUM_AXES-1:0]       over;
    logic signed [ACCEL_W-1:0] accel [NUM_AXES];
    t_result                   result;

    logic                      r_valid;
    t_result                   r_result;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_threshold   <= RST_ACCEL_THRESHOLD;
            r_count_limit       <= RST_COUNT_LIMIT;
            r_window_length     <= RST_WINDOW_LENGTH;
            r_warning_limit     <= RST_WARNING_LIMIT;
            r_gesture_threshold <= RST_GESTURE_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_ACCEL_THRESHOLD:   r_accel_threshold   <= $signed(i_cfg_data[ACCEL_W-1:0]);
                REG_COUNT_LIMIT:       r_count_limit       <= i_cfg_data[COUNT_W-1:0];
                REG_WINDOW_LENGTH:     r_window_length     <= i_cfg_data[WINDOW_W-1:0];
                REG_WARNING_LIMIT:     r_warning_limit     <= i_cfg_data[COUNT_W-1:0];
                REG_GESTURE_THRESHOLD: r_gesture_threshold <= i_cfg_data[GTHRESH_W-1:0];
                default: ;
            endcase
        end
    end

    // Accept while the output register is free or being drained
    assign o_ready = !r_valid || i_ready;
    assign advance = i_valid && o_ready;

    // Window age, modulo the time width
    assign now_t   = TIME_WIDTH'(i_now_ms);
    assign elapsed = now_t - r_window_start;

    assign lane_ctrl.advance = advance;
    assign lane_ctrl.expire  = (elapsed > TIME_WIDTH'(r_window_length));
    assign lane_ctrl.jerk    = result.jerk;

    // Restart the window at this sample's time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_start <= '0;
        end else if (advance && lane_ctrl.expire) begin
            r_window_start <= now_t;
        end
    end

    assign accel[0] = i_accel_x;
    assign accel[1] = i_accel_y;
    assign accel[2] = i_accel_z;

    // One hit-counting lane per axis
    for (genvar g = 0; g < NUM_AXES; g++) begin : g_lane
        jgd_axis_lane u_lane (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_accel       (accel[g]),
            .i_threshold   (r_accel_threshold),
            .i_count_limit (r_count_limit),
            .i_ctrl        (lane_ctrl),
            .o_over        (over[g])
        );
    end

    jgd_merge u_merge (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_advance           (advance),
        .i_over              (over),
        .i_gyro              (i_gyro_x),
        .i_warning_limit     (r_warning_limit),
        .i_gesture_threshold (r_gesture_threshold),
        .o_result            (result)
    );

    // Hold the result until it is taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= result;
        end
    end

    assign o_valid         = r_valid;
    assign o_motion        = r_result.motion;
    assign o_jerk          = r_result.jerk;
    assign o_jerk_axis     = r_result.jerk_axis;
    assign o_alert         = r_result.alert;
    assign o_warning_count = r_result.warning_count;
    assign o_gesture       = r_result.gesture;

    // A jerk item reports motion and never a gesture
    a_jerk_motion: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_jerk) |-> (o_motion && !o_gesture))
        else $error("jerk without motion or with gesture");

    // An alert comes only with a jerk and an emptied count
    a_alert_jerk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_alert) |-> (o_jerk && (o_warning_count == '0)))
        else $error("alert without jerk or with nonzero count");

    // Without a jerk the axis reads X and no alert shows
    a_quiet_axis: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_jerk) |-> ((o_jerk_axis == AXIS_X) && !o_alert))
        else $error("axis or alert set without a jerk");

endmodule : jerk_and_gesture_detector_unit
`default_nettype wire

### src/jgd_axis_lane.sv
// One acceleration axis: hit compare and saturating hit counter.
`default_nettype none
module jgd_axis_lane (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]   i_accel,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]   i_threshold,
    input  wire logic        [jgd_pkg::COUNT_W-1:0]   i_count_limit,
    input  wire jgd_pkg::t_lane_ctrl                  i_ctrl,
    output logic                                      o_over
);
    import jgd_pkg::*;

    logic [COUNT_W-1:0] r_count;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] bumped;
    logic               hit;

    // Count a hit, saturating at the top
    assign hit    = (i_accel > i_threshold);
    assign bumped = (hit && (r_count != COUNT_MAX)) ? r_count + COUNT_W'(1) : r_count;

    // A restarted window drops this item's hits before the limit check
    assign o_over = !i_ctrl.expire && (bumped > i_count_limit);

    // Clear on window restart or jerk, else keep the bumped count
    always_comb begin
        n_count = r_count;
        if (i_ctrl.advance) begin
            n_count = (i_ctrl.expire || i_ctrl.jerk) ? '0 : bumped;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

endmodule : jgd_axis_lane
`default_nettype wire

### src/jgd_merge.sv
// Merge stage: axis priority, warning count, alert and gyro gesture tracking.
`default_nettype none
module jgd_merge (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    input  wire logic                                 i_advance,
    input  wire logic [jgd_pkg::NUM_AXES-1:0]         i_over,
    input  wire logic signed [jgd_pkg::ACCEL_W-1:0]   i_gyro,
    input  wire logic [jgd_pkg::COUNT_W-1:0]          i_warning_limit,
    input  wire logic [jgd_pkg::GTHRESH_W-1:0]        i_gesture_threshold,
    output jgd_pkg::t_result                          o_result
);
    import jgd_pkg::*;

    localparam int unsigned GCMP_W = ACCEL_W + 1;

    logic               r_gesture_armed;
    logic               n_gesture_armed;
    logic [COUNT_W-1:0] r_warnings;
    logic [COUNT_W-1:0] n_warnings;
    logic [COUNT_W-1:0] warn_inc;
    logic               jerk;
    t_axis              axis;
    logic signed [GCMP_W-1:0] gyro_ext;
    logic signed [GCMP_W-1:0] thr_pos;
    logic signed [GCMP_W-1:0] thr_neg;
    logic               gyro_high;
    logic               gyro_low;

    // Pick the first axis over the limit, X before Y before Z
    always_comb begin
        jerk = 1'b1;
        axis = AXIS_X;
        if (i_over[0]) begin
            axis = AXIS_X;
        end else if (i_over[1]) begin
            axis = AXIS_Y;
        end else if (i_over[2]) begin
            axis = AXIS_Z;
        end else begin
            jerk = 1'b0;
        end
    end

    // Gyro compares against plus and minus the threshold
    assign gyro_ext  = GCMP_W'(i_gyro);
    assign thr_pos   = $signed({2'b00, i_gesture_threshold});
    assign thr_neg   = -thr_pos;
    assign gyro_high = (gyro_ext > thr_pos);
    assign gyro_low  = (gyro_ext < thr_neg);

    assign warn_inc = (r_warnings != COUNT_MAX) ? r_warnings + COUNT_W'(1) : r_warnings;

    // Form the result and the next warning and arm state
    always_comb begin
        n_warnings      = r_warnings;
        n_gesture_armed = r_gesture_armed;
        o_result        = '0;
        o_result.jerk      = jerk;
        o_result.jerk_axis = axis;
        if (jerk) begin
            n_warnings = warn_inc;
            if (warn_inc >= i_warning_limit) begin
                o_result.alert = 1'b1;
                n_warnings     = '0;
            end
        end else if (gyro_high) begin
            n_gesture_armed = 1'b1;
        end else if (gyro_low && r_gesture_armed) begin
            n_gesture_armed  = 1'b0;
            o_result.gesture = 1'b1;
        end
        o_result.motion        = jerk || o_result.gesture;
        o_result.warning_count = n_warnings;
    end

    // Advance state only on an accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_warnings      <= '0;
            r_gesture_armed <= 1'b0;
        end else if (i_advance) begin
            r_warnings      <= n_warnings;
            r_gesture_armed <= n_gesture_armed;
        end
    end

    // A quiet item leaves the warning count alone
    a_warn_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && !jerk) |=> $stable(r_warnings))
        else $error("warning count moved without a jerk");

    // A completed gesture disarms the tracker
    a_gesture_disarm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.gesture) |=> !r_gesture_armed)
        else $error("gesture tracker still armed after a gesture");

    // An alert always empties the warning count
    a_alert_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_advance && o_result.alert) |=> (r_warnings == '0))
        else $error("warning count not cleared after alert");

endmodule : jgd_merge
`default_nettype wire

### test/jgd_result_checker.sv
// Checker for the jerk and gesture detector: predicts each result item and compares it.
module jgd_result_checker
    import jgd_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Configuration write port, watched
    input  logic                       i_cfg_we,
    input  logic [CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [CFG_DATA_W-1:0]      i_cfg_data,
    // Sample channel, watched
    input  logic                       i_smp_valid,
    input  logic                       i_smp_ready,
    input  logic [NOW_W-1:0]           i_now_ms,
    input  logic signed [ACCEL_W-1:0]  i_accel_x,
    input  logic signed [ACCEL_W-1:0]  i_accel_y,
    input  logic signed [ACCEL_W-1:0]  i_accel_z,
    input  logic signed [ACCEL_W-1:0]  i_gyro_x,
    // Result channel, watched
    input  logic                       i_res_valid,
    input  logic                       i_res_ready,
    input  logic                       i_motion,
    input  logic                       i_jerk,
    input  logic [AXIS_W-1:0]          i_jerk_axis,
    input  logic                       i_alert,
    input  logic [COUNT_W-1:0]         i_warning_count,
    input  logic                       i_gesture,
    // Status for the testbench top
    output int                         o_fail_count,
    output int                         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Local copy of the configuration registers
    logic signed [ACCEL_W-1:0] accel_level;
    logic [COUNT_W-1:0]        hit_limit;
    logic [WINDOW_W-1:0]       window_span;
    logic [COUNT_W-1:0]        alert_limit;
    logic [GTHRESH_W-1:0]      swing_level;

    // Local copy of the detector state
    logic [COUNT_W-1:0] hit_count [NUM_AXES];
    logic [NOW_W-1:0]   window_origin;
    logic [COUNT_W-1:0] warning_tally;
    logic               swing_armed;

    t_result expected_results [$];

    // Advance the local detector by one sample and return its result item
    function automatic t_result detect_motion(
        input logic [NOW_W-1:0]          now_ms,
        input logic signed [ACCEL_W-1:0] accel_x,
        input logic signed [ACCEL_W-1:0] accel_y,
        input logic signed [ACCEL_W-1:0] accel_z,
        input logic signed [ACCEL_W-1:0] gyro_x
    );
        t_result                   res;
        logic signed [ACCEL_W-1:0] accel [NUM_AXES];
        logic signed [ACCEL_W:0]   rate;
        logic signed [ACCEL_W:0]   swing_pos;
        logic signed [ACCEL_W:0]   swing_neg;
        logic [NOW_W-1:0]          elapsed;
        logic                      fire;
        t_axis                     axis;

        res = '0;
        accel[0] = accel_x;
        accel[1] = accel_y;
        accel[2] = accel_z;

        // Count hits per axis, saturating
        for (int a = 0; a < NUM_AXES; a++) begin
            if (accel[a] > accel_level && hit_count[a] != COUNT_MAX) begin
                hit_count[a] = hit_count[a] + 1'b1;
            end
        end

        // Restart the window once it has run out; this drops the new hits too
        elapsed = now_ms - window_origin;
        if (elapsed > {{(NOW_W-WINDOW_W){1'b0}}, window_span}) begin
            window_origin = now_ms;
            for (int a = 0; a < NUM_AXES; a++) hit_count[a] = '0;
        end

        // First axis over the limit wins, X before Y before Z
        fire = 1'b0;
        axis = AXIS_X;
        if (hit_count[0] > hit_limit) begin
            fire = 1'b1;
            axis = AXIS_X;
        end else if (hit_count[1] > hit_limit) begin
            fire = 1'b1;
            axis = AXIS_Y;
        end else if (hit_count[2] > hit_limit) begin
            fire = 1'b1;
            axis = AXIS_Z;
        end

        rate      = gyro_x;
        swing_pos = $signed({2'b00, swing_level});
        swing_neg = -swing_pos;

        if (fire) begin
            for (int a = 0; a < NUM_AXES; a++) hit_count[a] = '0;
            if (warning_tally != COUNT_MAX) warning_tally = warning_tally + 1'b1;
            if (warning_tally >= alert_limit) begin
                res.alert     = 1'b1;
                warning_tally = '0;
            end
        end else if (rate > swing_pos) begin
            swing_armed = 1'b1;
        end else if (rate < swing_neg) begin
            if (swing_armed) begin
                swing_armed = 1'b0;
                res.gesture = 1'b1;
            end
        end

        res.jerk          = fire;
        res.jerk_axis     = axis;
        res.motion        = fire | res.gesture;
        res.warning_count = warning_tally;
        return res;
    endfunction

    // Report one field that differs from its prediction
    task automatic check_field(input string name, input logic [7:0] want,
                               input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_result want;

        if (!i_rst_n) begin
            accel_level   = RST_ACCEL_THRESHOLD;
            hit_limit     = RST_COUNT_LIMIT;
            window_span   = RST_WINDOW_LENGTH;
            alert_limit   = RST_WARNING_LIMIT;
            swing_level   = RST_GESTURE_THRESHOLD;
            for (int a = 0; a < NUM_AXES; a++) hit_count[a] = '0;
            window_origin = '0;
            warning_tally = '0;
            swing_armed   = 1'b0;
            expected_results.delete();
            o_fail_count  = 0;
        end else begin
            // Compare a taken result item with the oldest prediction
            if (i_res_valid && i_res_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no prediction waiting");
                    o_fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("motion", want.motion, i_motion);
                    check_field("jerk", want.jerk, i_jerk);
                    check_field("jerk_axis", want.jerk_axis, i_jerk_axis);
                    check_field("alert", want.alert, i_alert);
                    check_field("warning_count", want.warning_count, i_warning_count);
                    check_field("gesture", want.gesture, i_gesture);
                end
            end

            // Predict the result of an accepted sample
            if (i_smp_valid && i_smp_ready) begin
                expected_results.push_back(
                    detect_motion(i_now_ms, i_accel_x, i_accel_y, i_accel_z, i_gyro_x));
            end

            // Track register writes; unknown indexes change nothing
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_ACCEL_THRESHOLD:   accel_level = i_cfg_data;
                    REG_COUNT_LIMIT:       hit_limit   = i_cfg_data[COUNT_W-1:0];
                    REG_WINDOW_LENGTH:     window_span = i_cfg_data[WINDOW_W-1:0];
                    REG_WARNING_LIMIT:     alert_limit = i_cfg_data[COUNT_W-1:0];
                    REG_GESTURE_THRESHOLD: swing_level = i_cfg_data[GTHRESH_W-1:0];
                    default: ;
                endcase
            end
        end
        o_pending = expected_results.size();
    end

endmodule : jgd_result_checker

### test/tb_jerk_and_gesture_detector_unit.sv
// Testbench top for the jerk and gesture detector: clock, reset, stimulus and verdict.
module tb_jerk_and_gesture_detector_unit;
    timeunit 1ns;
    timeprecision 1ps;
    import jgd_pkg::*;

    localparam int CLK_HALF       = 5;
    localparam int RESET_CYCLES   = 3;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int NUM_PHASES     = 10;
    localparam int PHASE_ITEMS    = 95;
    localparam int SAT_ITEMS      = 300;
    localparam int SETTLE_CYCLES  = 4;

    // First register index that the block does not decode
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;

    typedef enum int {
        PHASE_MIXED,
        PHASE_SATURATE,
        PHASE_LOW_EXTREMES,
        PHASE_HIGH_EXTREMES
    } t_phase_kind;

    typedef struct {
        logic [NOW_W-1:0]          now_ms;
        logic signed [ACCEL_W-1:0] accel_x;
        logic signed [ACCEL_W-1:0] accel_y;
        logic signed [ACCEL_W-1:0] accel_z;
        logic signed [ACCEL_W-1:0] gyro_x;
    } t_motion_sample;

    logic                      i_clk;
    logic                      i_rst_n;
    logic                      i_cfg_we;
    logic [CFG_IDX_W-1:0]      i_cfg_idx;
    logic [CFG_DATA_W-1:0]     i_cfg_data;
    logic                      i_valid;
    logic                      o_ready;
    logic [NOW_W-1:0]          i_now_ms;
    logic signed [ACCEL_W-1:0] i_accel_x;
    logic signed [ACCEL_W-1:0] i_accel_y;
    logic signed [ACCEL_W-1:0] i_accel_z;
    logic signed [ACCEL_W-1:0] i_gyro_x;
    logic                      o_valid;
    logic                      i_ready;
    logic                      o_motion;
    logic                      o_jerk;
    logic [AXIS_W-1:0]         o_jerk_axis;
    logic                      o_alert;
    logic [COUNT_W-1:0]        o_warning_count;
    logic                      o_gesture;

    int   result_failures;
    int   pending_results;
    logic stall_free;
    int   stall_left;
    int   idle_cycles;

    jerk_and_gesture_detector_unit dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_now_ms        (i_now_ms),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_gyro_x        (i_gyro_x),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_motion        (o_motion),
        .o_jerk          (o_jerk),
        .o_jerk_axis     (o_jerk_axis),
        .o_alert         (o_alert),
        .o_warning_count (o_warning_count),
        .o_gesture       (o_gesture)
    );

    jgd_result_checker u_result_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_smp_valid     (i_valid),
        .i_smp_ready     (o_ready),
        .i_now_ms        (i_now_ms),
        .i_accel_x       (i_accel_x),
        .i_accel_y       (i_accel_y),
        .i_accel_z       (i_accel_z),
        .i_gyro_x        (i_gyro_x),
        .i_res_valid     (o_valid),
        .i_res_ready     (i_ready),
        .i_motion        (o_motion),
        .i_jerk          (o_jerk),
        .i_jerk_axis     (o_jerk_axis),
        .i_alert         (o_alert),
        .i_warning_count (o_warning_count),
        .i_gesture       (o_gesture),
        .o_fail_count    (result_failures),
        .o_pending       (pending_results)
    );

    // Free-running clock
    initial i_clk = 1'b0;
    always #CLK_HALF i_clk = ~i_clk;

    // Gap length: mostly none, some short, a few long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(99, 0);
        if (stall_free || roll < 60) return 0;
        if (roll < 90) return $urandom_range(3, 1);
        if (roll < 97) return $urandom_range(10, 4);
        return $urandom_range(60, 20);
    endfunction

    // Acceleration value aimed at or away from the hit level
    function automatic logic signed [ACCEL_W-1:0] pick_accel(
        input logic signed [ACCEL_W-1:0] level, input int hit_pct);
        int roll;
        int lvl;
        int value;
        roll = $urandom_range(99, 0);
        lvl  = level;
        if (roll < 5) begin
            value = lvl;
        end else if (roll < 15) begin
            value = $urandom;
        end else if ($urandom_range(99, 0) < hit_pct && lvl < 32767) begin
            value = lvl + 1 + int'($urandom_range(32767 - lvl - 1, 0));
        end else if (lvl > -32768) begin
            value = -32768 + int'($urandom_range(lvl + 32768 - 1, 0));
        end else begin
            value = lvl;
        end
        return value[ACCEL_W-1:0];
    endfunction

    // Gyro rate around the positive and negative swing levels
    function automatic logic signed [ACCEL_W-1:0] pick_gyro(
        input logic [GTHRESH_W-1:0] level);
        int roll;
        int lvl;
        int value;
        roll = $urandom_range(99, 0);
        lvl  = level;
        if (roll < 30 && lvl < 32767) begin
            value = lvl + 1 + int'($urandom_range(32767 - lvl - 1, 0));
        end else if (roll < 60) begin
            value = -32768 + int'($urandom_range(32767 - lvl, 0));
        end else if (roll < 68) begin
            value = lvl;
        end else if (roll < 75) begin
            value = -lvl;
        end else begin
            value = $urandom;
        end
        return value[ACCEL_W-1:0];
    endfunction

    function automatic t_motion_sample motion_sample(input logic [NOW_W-1:0] now_ms,
                                                     input int ax, input int ay,
                                                     input int az, input int gx);
        t_motion_sample s;
        s.now_ms  = now_ms;
        s.accel_x = ax[ACCEL_W-1:0];
        s.accel_y = ay[ACCEL_W-1:0];
        s.accel_z = az[ACCEL_W-1:0];
        s.gyro_x  = gx[ACCEL_W-1:0];
        return s;
    endfunction

    // Write one register; only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
    endtask

    // Offer one sample after a gap and hold it until accepted
    task automatic send_sample(input t_motion_sample s, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid   <= 1'b1;
        i_now_ms  <= s.now_ms;
        i_accel_x <= s.accel_x;
        i_accel_y <= s.accel_y;
        i_accel_z <= s.accel_z;
        i_gyro_x  <= s.gyro_x;
        do @(posedge i_clk); while (!o_ready);
    endtask

    // Drop valid and hold off until every predicted item has come out
    task automatic drain_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_results != 0) @(negedge i_clk);
        repeat (2) @(negedge i_clk);
    endtask

    // One configuration setting followed by a burst of random samples
    task automatic run_random_phase(input t_phase_kind kind);
        logic signed [ACCEL_W-1:0] accel_lvl;
        logic [COUNT_W-1:0]        count_lim;
        logic [WINDOW_W-1:0]       win_len;
        logic [COUNT_W-1:0]        warn_lim;
        logic [CFG_DATA_W-1:0]     gyro_data;
        logic [NOW_W-1:0]          now_ms;
        int                        hit_pct;
        int                        step_max;
        int                        jump_pct;
        int                        items;

        // Settle the setting for this phase
        hit_pct  = $urandom_range(90, 10);
        jump_pct = 2;
        items    = PHASE_ITEMS;
        case (kind)
            PHASE_SATURATE: begin
                // Axes hit on most samples, the window restarts at most once, counters pin at the top
                accel_lvl = 16'sh8000;
                count_lim = COUNT_MAX;
                win_len   = 16'hFFFF;
                warn_lim  = 8'($urandom);
                gyro_data = 16'($urandom);
                hit_pct   = 100;
                step_max  = 0;
                jump_pct  = 0;
                items     = SAT_ITEMS;
            end
            PHASE_LOW_EXTREMES: begin
                accel_lvl = 16'sh8000;
                count_lim = '0;
                win_len   = 16'd1;
                warn_lim  = 8'd1;
                gyro_data = 16'h8000;
                step_max  = 1;
            end
            PHASE_HIGH_EXTREMES: begin
                accel_lvl = 16'sh7FFF;
                count_lim = 8'd254;
                win_len   = 16'hFFFF;
                warn_lim  = 8'd255;
                gyro_data = 16'h7FFF;
                step_max  = 50;
            end
            default: begin
                accel_lvl = $urandom_range(1, 0) ? 16'($urandom)
                                                 : 16'(int'($urandom_range(6000, 0)) - 1000);
                count_lim = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(254, 0))
                                                        : 8'($urandom_range(12, 0));
                win_len   = $urandom_range(1, 0) ? 16'($urandom_range(65535, 1))
                                                 : 16'($urandom_range(300, 1));
                warn_lim  = ($urandom_range(3, 0) == 0) ? 8'($urandom_range(255, 0))
                                                        : 8'($urandom_range(6, 0));
                gyro_data = 16'($urandom);
                step_max  = win_len / $urandom_range(40, 4);
            end
        endcase

        write_reg(REG_ACCEL_THRESHOLD, accel_lvl);
        write_reg(REG_COUNT_LIMIT, {8'($urandom), count_lim});
        write_reg(REG_WINDOW_LENGTH, win_len);
        write_reg(REG_WARNING_LIMIT, {8'($urandom), warn_lim});
        write_reg(REG_GESTURE_THRESHOLD, gyro_data);
        write_reg(CFG_IDX_W'($urandom_range(2**CFG_IDX_W - 1, REG_SPARE_FIRST)),
                  16'($urandom));

        now_ms = ($urandom_range(2, 0) == 0) ? 32'hFFFF_FFFF - $urandom_range(4000, 0)
                                             : $urandom;
        stall_free = ($urandom_range(3, 0) == 0);

        for (int i = 0; i < items; i++) begin
            // Hold the sender once mid-phase until the output side catches up
            if (i == items / 2) drain_results();
            if ($urandom_range(99, 0) < jump_pct) now_ms = $urandom;
            else now_ms = now_ms + $urandom_range(step_max, 0);
            send_sample(motion_sample(now_ms,
                                      pick_accel(accel_lvl, hit_pct),
                                      pick_accel(accel_lvl, hit_pct),
                                      pick_accel(accel_lvl, hit_pct),
                                      pick_gyro(gyro_data[GTHRESH_W-1:0])),
                        pick_gap());
        end
        drain_results();
        stall_free = 1'b0;
    endtask

    // Result side: random stalls, none while stall_free is set
    always @(negedge i_clk) begin
        if (stall_left == 0 && !stall_free && $urandom_range(2, 0) == 0) begin
            stall_left = pick_gap();
        end
        if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left--;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("FAILURE");
        $finish;
    end

    // Stimulus and verdict
    initial begin
        i_rst_n    = 1'b0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = '0;
        i_cfg_data = '0;
        i_valid    = 1'b0;
        i_now_ms   = '0;
        i_accel_x  = '0;
        i_accel_y  = '0;
        i_accel_z  = '0;
        i_gyro_x   = '0;
        i_ready    = 1'b0;
        stall_free = 1'b0;
        stall_left = 0;

        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset setting: field extremes, a full gyro swing, window restart
        send_sample(motion_sample(32'd10, 0, 0, 0, 0), pick_gap());
        send_sample(motion_sample(32'd20, 32767, -32768, 32767, 32767), pick_gap());
        send_sample(motion_sample(32'd30, -32768, 32767, -32768, -32768), pick_gap());
        send_sample(motion_sample(32'd40, 0, 0, 0, -32768), pick_gap());
        send_sample(motion_sample(32'd5000, 3201, 3200, 0, 0), pick_gap());
        drain_results();

        // Jerk on any single hit: each axis, alert, gesture held across a jerk
        write_reg(REG_COUNT_LIMIT, 16'd0);
        write_reg(REG_WINDOW_LENGTH, 16'hFFFF);
        send_sample(motion_sample(32'd5001, 4000, 0, 0, 0), pick_gap());
        send_sample(motion_sample(32'd5002, 0, 4000, 0, 0), pick_gap());
        send_sample(motion_sample(32'd5003, 0, 0, 4000, 32767), pick_gap());
        send_sample(motion_sample(32'd5004, 0, 0, 0, -32768), pick_gap());
        send_sample(motion_sample(32'd5005, 0, 0, 0, 32767), pick_gap());
        send_sample(motion_sample(32'd5006, 4000, 0, 0, -32768), pick_gap());
        send_sample(motion_sample(32'd5007, 0, 0, 0, -32768), pick_gap());
        send_sample(motion_sample(32'd5008, 4000, 4000, 4000, 0), pick_gap());
        send_sample(motion_sample(32'd5009, 3200, 3201, 0, 0), pick_gap());
        drain_results();

        // Short window across the time wrap
        write_reg(REG_WINDOW_LENGTH, 16'd100);
        send_sample(motion_sample(32'hFFFF_FFC0, 4000, 0, 0, 0), pick_gap());
        send_sample(motion_sample(32'h0000_0010, 4000, 0, 0, 0), pick_gap());
        send_sample(motion_sample(32'h0000_0030, 4000, 0, 0, 0), pick_gap());
        drain_results();

        // Warning limit zero, gesture level zero, lowest hit level, undecoded indexes
        write_reg(REG_WARNING_LIMIT, 16'd0);
        write_reg(REG_GESTURE_THRESHOLD, 16'd0);
        write_reg(REG_ACCEL_THRESHOLD, 16'h8000);
        for (int k = REG_SPARE_FIRST; k < 2**CFG_IDX_W; k++) begin
            write_reg(CFG_IDX_W'(k), 16'hFFFF);
        end
        send_sample(motion_sample(32'h0000_0040, -32767, 0, 0, 0), pick_gap());
        send_sample(motion_sample(32'h0000_0041, -32768, -32768, -32768, 1), pick_gap());
        send_sample(motion_sample(32'h0000_0042, -32768, -32768, -32768, -1), pick_gap());
        send_sample(motion_sample(32'h0000_0043, -32768, -32768, -32768, 0), pick_gap());
        drain_results();

        // Highest levels: nothing can hit or arm
        write_reg(REG_ACCEL_THRESHOLD, 16'h7FFF);
        write_reg(REG_GESTURE_THRESHOLD, 16'hFFFF);
        write_reg(REG_WARNING_LIMIT, 16'd255);
        write_reg(REG_COUNT_LIMIT, 16'd254);
        send_sample(motion_sample(32'h0000_0050, 32767, 32767, 32767, 32767), pick_gap());
        send_sample(motion_sample(32'h0000_0051, 0, 0, 0, -32768), pick_gap());
        drain_results();

        // Random phases, a few of them at fixed extreme settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            case (p)
                1:       run_random_phase(PHASE_SATURATE);
                2:       run_random_phase(PHASE_LOW_EXTREMES);
                3:       run_random_phase(PHASE_HIGH_EXTREMES);
                default: run_random_phase(PHASE_MIXED);
            endcase
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (result_failures == 0 && pending_results == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule : tb_jerk_and_gesture_detector_unit

### filelist.f
src/jgd_pkg.sv
src/jgd_axis_lane.sv
src/jgd_merge.sv
src/jerk_and_gesture_detector_unit.sv
test/jgd_result_checker.sv
test/tb_jerk_and_gesture_detector_unit.sv
